// ----- src/cll_pkg.sv -----
// Shared types and constants of the C-like lexer unit.
package cll_pkg;

  // Lexer modes between bytes.
  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_IDENT    = 4'd1,
    M_NUMBER   = 4'd2,
    M_OPRUN    = 4'd3,
    M_MINUS    = 4'd4,
    M_SLASH    = 4'd5,
    M_CHARLIT  = 4'd6,
    M_STRING   = 4'd7,
    M_LINECOM  = 4'd8,
    M_BLOCKCOM = 4'd9
  } lex_mode_e;

  // Token class codes as they leave the block.
  typedef enum logic [3:0] {
    TC_CHAR      = 4'd0,
    TC_STRING    = 4'd1,
    TC_IDENT     = 4'd2,
    TC_NUMBER    = 4'd3,
    TC_OPERATOR  = 4'd4,
    TC_LPAREN    = 4'd5,
    TC_RPAREN    = 4'd6,
    TC_LBRACE    = 4'd7,
    TC_RBRACE    = 4'd8,
    TC_LBRACK    = 4'd9,
    TC_RBRACK    = 4'd10,
    TC_SEMICOLON = 4'd11,
    TC_UNKNOWN   = 4'd12
  } tok_class_e;

  // One token record.
  typedef struct packed {
    tok_class_e  cls;
    logic [15:0] line;
    logic [15:0] col;
    logic [31:0] off;
    logic [15:0] len;
    logic        last;
  } tok_rec_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // Character codes.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= CH_LO_A) && (b <= CH_LO_Z)) || ((b >= CH_UP_A) && (b <= CH_UP_Z));
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    return (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_STAR) || (b == CH_SLASH) ||
           (b == CH_PCT) || (b == CH_AMP) || (b == CH_BAR) || (b == CH_CARET) ||
           (b == CH_TILDE) || (b == CH_BANG) || (b == CH_EQ) || (b == CH_LT) ||
           (b == CH_GT) || (b == CH_QUEST) || (b == CH_COLON) || (b == CH_HASH) ||
           (b == CH_DOT) || (b == CH_COMMA);
  endfunction

  // Modes that hold a pending token.
  function automatic logic is_token_mode(input lex_mode_e m);
    return (m != M_IDLE) && (m != M_LINECOM) && (m != M_BLOCKCOM);
  endfunction

  function automatic tok_class_e mode_class(input lex_mode_e m);
    tok_class_e c;
    unique case (m)
      M_IDENT:   c = TC_IDENT;
      M_NUMBER:  c = TC_NUMBER;
      M_CHARLIT: c = TC_CHAR;
      M_STRING:  c = TC_STRING;
      default:   c = TC_OPERATOR;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

endpackage

// ----- src/c_like_lexer_unit.sv -----
// Top level of the C-like lexer unit: input register, lexer step and record queue.
//
// Usage: source text enters one byte per beat on the input channel
// (text_byte_i, end_of_text_i). Every finished token leaves as one record
// beat on the output channel: class, line and column of its first byte,
// byte offset and length. Whitespace and comments produce no beats. A byte
// that ends one token and completes another gives two beats in order, and
// last_of_run_o marks the final beat caused by a byte.
// Path: a byte accepted into the input register is lexed from there, and its
// records are written into the record queue, whose head drives the output port.
// Throughput: one byte per cycle as long as bytes give at most one record
// each on average and the receiver does not stall; the single output port drains
// one record per cycle, so bytes that give two records slow the input down there. A
// four-entry record queue parts the lexer from the receiver, and the input register
// holds a byte (with in_stall_o high) whenever the queue has less than two free slots.
// Reset clears the lexer to line 1, column 1, offset 0 with no pending token, and
// empties the queue. A receiver stall holds the head record and, once the queue fills,
// the input; end_of_text_i flushes the pending token and restarts the position count.
module c_like_lexer_unit
  import cll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_class_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic [31:0] token_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  // Input register.
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       eot_q;

  // Lexer state.
  lex_mode_e   mode_q, mode_d;
  logic [7:0]  held_q, held_d;
  logic        bsl_q, bsl_d;
  logic        exp_q, exp_d;
  logic [1:0]  chs_q, chs_d;
  logic [31:0] p_off_q, p_off_d;
  logic [15:0] p_len_q, p_len_d;
  logic [15:0] p_line_q, p_line_d;
  logic [15:0] p_col_q, p_col_d;
  logic [15:0] cur_line_q, cur_line_d;
  logic [15:0] cur_col_q, cur_col_d;
  logic [31:0] cur_off_q, cur_off_d;

  // Step results shared between the next-state and record blocks.
  logic        fifo_room;
  logic        proc;
  logic        cont, close;
  lex_mode_e   m1, m2;
  logic [15:0] len1, len_g;
  logic        exp1, bsl1, held_clr;
  logic [1:0]  chs1;
  logic [7:0]  held1;
  logic        single;
  tok_class_e  single_cls;
  logic        exp2, bsl2;
  logic [1:0]  chs2;
  logic [31:0] off2;
  logic [15:0] len2, line2, col2;
  logic        flush;

  tok_rec_t    rec_a, rec_b, wr0, wr1, head;
  logic        a_vld;
  logic [1:0]  push_cnt;

  assign proc       = in_vld_q && fifo_room;
  assign in_stall_o = in_vld_q && !fifo_room;
  assign in_vld_d   = (in_valid_i && !in_stall_o) || (in_vld_q && !fifo_room);
  assign len_g      = sat_inc16(p_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  // Next state: continue the current mode, else start a new token.
  always_comb begin
    cont     = 1'b0;
    close    = 1'b0;
    m1       = mode_q;
    len1     = p_len_q;
    exp1     = exp_q;
    chs1     = chs_q;
    bsl1     = bsl_q;
    held1    = held_q;
    held_clr = 1'b0;

    unique case (mode_q)
      M_IDENT: begin
        if (is_word(byte_q)) begin
          cont = 1'b1;
          len1 = len_g;
        end
      end
      M_NUMBER: begin
        if (!exp_q) begin
          if (is_digit(byte_q) || byte_q == CH_DOT) begin
            cont = 1'b1;
            len1 = len_g;
          end else if (byte_q == CH_LO_E) begin
            cont = 1'b1;
            len1 = len_g;
            exp1 = 1'b1;
          end
        end else if (is_digit(byte_q) || byte_q == CH_LO_E) begin
          cont = 1'b1;
          len1 = len_g;
        end
      end
      M_MINUS: begin
        if (is_digit(byte_q) || byte_q == CH_DOT) begin
          cont = 1'b1;
          len1 = len_g;
          m1   = M_NUMBER;
          exp1 = 1'b0;
        end else if (is_op(byte_q)) begin
          cont = 1'b1;
          len1 = len_g;
          m1   = M_OPRUN;
        end
      end
      M_SLASH: begin
        if (byte_q == CH_SLASH) begin
          cont = 1'b1;
          m1   = M_LINECOM;
        end else if (byte_q == CH_STAR) begin
          cont     = 1'b1;
          m1       = M_BLOCKCOM;
          held_clr = 1'b1;
        end else if (is_op(byte_q)) begin
          cont = 1'b1;
          len1 = len_g;
          m1   = M_OPRUN;
        end
      end
      M_OPRUN: begin
        if (is_op(byte_q)) begin
          cont = 1'b1;
          len1 = len_g;
        end
      end
      M_CHARLIT: begin
        if (chs_q == 2'd0) begin
          cont = 1'b1;
          len1 = len_g;
          chs1 = (byte_q == CH_BSLASH) ? 2'd1 : 2'd2;
        end else if (chs_q == 2'd1) begin
          cont = 1'b1;
          len1 = len_g;
          chs1 = 2'd2;
        end else if (byte_q == CH_SQUOTE) begin
          cont  = 1'b1;
          len1  = len_g;
          close = 1'b1;
          m1    = M_IDLE;
        end
      end
      M_STRING: begin
        cont = 1'b1;
        len1 = len_g;
        if (byte_q == CH_DQUOTE && !bsl_q) begin
          close = 1'b1;
          m1    = M_IDLE;
        end else begin
          bsl1 = (byte_q == CH_BSLASH);
        end
      end
      M_LINECOM: begin
        if (byte_q == CH_NL) begin
          m1 = M_IDLE;
        end else begin
          cont = 1'b1;
        end
      end
      M_BLOCKCOM: begin
        cont = 1'b1;
        if (held_q == CH_STAR && byte_q == CH_SLASH) begin
          m1       = M_IDLE;
          held_clr = 1'b1;
        end else begin
          held1 = byte_q;
        end
      end
      default: begin
        cont = 1'b0;
      end
    endcase
    if (held_clr) begin
      held1 = 8'd0;
    end

    // Start of a new token when the byte was not absorbed.
    m2         = m1;
    exp2       = exp1;
    chs2       = chs1;
    bsl2       = bsl1;
    off2       = p_off_q;
    len2       = len1;
    line2      = p_line_q;
    col2       = p_col_q;
    single     = 1'b0;
    single_cls = TC_UNKNOWN;
    if (!cont) begin
      m2 = M_IDLE;
      if (!is_space(byte_q)) begin
        priority if (byte_q == CH_SLASH) begin
          m2 = M_SLASH;
        end else if (byte_q == CH_SQUOTE) begin
          m2   = M_CHARLIT;
          chs2 = 2'd0;
        end else if (byte_q == CH_DQUOTE) begin
          m2   = M_STRING;
          bsl2 = 1'b0;
        end else if (is_alpha(byte_q) || byte_q == CH_UNDER) begin
          m2 = M_IDENT;
        end else if (byte_q == CH_MINUS) begin
          m2 = M_MINUS;
        end else if (is_digit(byte_q)) begin
          m2   = M_NUMBER;
          exp2 = 1'b0;
        end else if (is_op(byte_q)) begin
          m2 = M_OPRUN;
        end else begin
          single = 1'b1;
          priority case (byte_q)
            CH_LPAREN: single_cls = TC_LPAREN;
            CH_RPAREN: single_cls = TC_RPAREN;
            CH_LBRACE: single_cls = TC_LBRACE;
            CH_RBRACE: single_cls = TC_RBRACE;
            CH_LBRACK: single_cls = TC_LBRACK;
            CH_RBRACK: single_cls = TC_RBRACK;
            CH_SEMI:   single_cls = TC_SEMICOLON;
            default:   single_cls = TC_UNKNOWN;
          endcase
        end
        if (!single) begin
          off2  = cur_off_q;
          len2  = 16'd1;
          line2 = cur_line_q;
          col2  = cur_col_q;
        end
      end
    end

    flush = eot_q && is_token_mode(m2);

    // Commit.
    mode_d     = mode_q;
    held_d     = held_q;
    bsl_d      = bsl_q;
    exp_d      = exp_q;
    chs_d      = chs_q;
    p_off_d    = p_off_q;
    p_len_d    = p_len_q;
    p_line_d   = p_line_q;
    p_col_d    = p_col_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    cur_off_d  = cur_off_q;
    if (proc) begin
      if (eot_q) begin
        mode_d     = M_IDLE;
        held_d     = 8'd0;
        bsl_d      = 1'b0;
        exp_d      = 1'b0;
        chs_d      = 2'd0;
        p_off_d    = 32'd0;
        p_len_d    = 16'd0;
        p_line_d   = 16'd1;
        p_col_d    = 16'd1;
        cur_line_d = 16'd1;
        cur_col_d  = 16'd1;
        cur_off_d  = 32'd0;
      end else begin
        mode_d   = m2;
        held_d   = held1;
        bsl_d    = bsl2;
        exp_d    = exp2;
        chs_d    = chs2;
        p_off_d  = off2;
        p_len_d  = len2;
        p_line_d = line2;
        p_col_d  = col2;
        if (byte_q == CH_NL) begin
          cur_line_d = sat_inc16(cur_line_q);
          cur_col_d  = 16'd1;
        end else begin
          cur_col_d = sat_inc16(cur_col_q);
        end
        cur_off_d = cur_off_q + 32'd1;
      end
    end
  end

  // Records: the finished old token first, then a one-byte token or the flush.
  always_comb begin
    a_vld = close || (!cont && is_token_mode(mode_q));

    rec_a.cls  = mode_class(mode_q);
    rec_a.line = p_line_q;
    rec_a.col  = p_col_q;
    rec_a.off  = p_off_q;
    rec_a.len  = len1;
    rec_a.last = 1'b0;

    if (single) begin
      rec_b.cls  = single_cls;
      rec_b.line = cur_line_q;
      rec_b.col  = cur_col_q;
      rec_b.off  = cur_off_q;
      rec_b.len  = 16'd1;
    end else begin
      rec_b.cls  = mode_class(m2);
      rec_b.line = line2;
      rec_b.col  = col2;
      rec_b.off  = off2;
      rec_b.len  = len2;
    end
    rec_b.last = 1'b1;

    wr0 = a_vld ? rec_a : rec_b;
    wr1 = rec_b;
    wr0.last = !(a_vld && (single || flush));

    push_cnt = proc ? ({1'b0, a_vld} + {1'b0, single || flush}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      held_q     <= 8'd0;
      bsl_q      <= 1'b0;
      exp_q      <= 1'b0;
      chs_q      <= 2'd0;
      p_off_q    <= 32'd0;
      p_len_q    <= 16'd0;
      p_line_q   <= 16'd1;
      p_col_q    <= 16'd1;
      cur_line_q <= 16'd1;
      cur_col_q  <= 16'd1;
      cur_off_q  <= 32'd0;
    end else begin
      mode_q     <= mode_d;
      held_q     <= held_d;
      bsl_q      <= bsl_d;
      exp_q      <= exp_d;
      chs_q      <= chs_d;
      p_off_q    <= p_off_d;
      p_len_q    <= p_len_d;
      p_line_q   <= p_line_d;
      p_col_q    <= p_col_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      cur_off_q  <= cur_off_d;
    end
  end

  cll_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .wr0_i       (wr0),
    .wr1_i       (wr1),
    .room_o      (fifo_room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rec_o   (head)
  );

  assign token_class_o  = head.cls;
  assign token_line_o   = head.line;
  assign token_column_o = head.col;
  assign token_offset_o = head.off;
  assign token_length_o = head.len;
  assign last_of_run_o  = head.last;

  a_eot_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && eot_q) |=> (mode_q == M_IDLE && cur_off_q == 32'd0 && cur_line_q == 16'd1))
    else $error("end of text did not restart the lexer");

  a_offset_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !eot_q) |=> cur_off_q == $past(cur_off_q) + 32'd1)
    else $error("byte offset did not advance by one");

  a_pending_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != M_IDLE && mode_q != M_LINECOM && mode_q != M_BLOCKCOM) |-> p_len_q != 16'd0)
    else $error("pending token with zero length");

  a_stall_needs_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with an empty input register");

endmodule

// ----- src/cll_fifo.sv -----
// Record queue of four: up to two records in per cycle, one out unless stalled.
module cll_fifo
  import cll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic [1:0] push_cnt_i,
  input  tok_rec_t wr0_i,
  input  tok_rec_t wr1_i,
  output logic     room_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tok_rec_t out_rec_o
);

  tok_rec_t mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_rec_o   = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
  assign count_d  = count_q + FIFO_CNT_W'(push_cnt_i) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= wr1_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("record queue overflow");

  a_push_with_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> room_o)
    else $error("records pushed without room for two");

  a_pop_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_cnt_i == 2'd0) |=> count_q == $past(count_q) - FIFO_CNT_W'(1))
    else $error("queue count wrong after a pop");

endmodule

// ----- verif/c_like_lexer_unit_tb.sv -----
// Self-checking testbench of the C-like lexer unit: byte stimulus, token prediction and checks.
module c_like_lexer_unit_tb
  import cll_pkg::*;
;

  // The cycle limit leaves a wide margin for a correct run, even if every byte gave two
  // records under the heaviest idling on both sides.
  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned RANDOM_BYTES = 1800;
  localparam logic [7:0] CH_VTAB = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i = 8'h00;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  token_class_o;
  logic [15:0] token_line_o;
  logic [15:0] token_column_o;
  logic [31:0] token_offset_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  c_like_lexer_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Test-wide bookkeeping. When idle_on is low neither side inserts random gaps.
  bit          idle_on = 1'b1;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned tokens_checked = 0;
  int unsigned cycle_count = 0;

  // A bump of hold_req asks the receiver for one long hold-off; the receiver counts it
  // down itself in hold_left.
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Token records still owed by the block, oldest first.
  tok_rec_t expected_tokens[$];

  // Lexer state of the predictor.
  lex_mode_e   lx_mode;
  logic [7:0]  lx_held;
  logic        lx_escape;
  logic        lx_exp_seen;
  logic [1:0]  lx_char_step;
  logic [31:0] tok_off;
  logic [15:0] tok_len;
  logic [15:0] tok_line;
  logic [15:0] tok_col;
  logic [15:0] pos_line;
  logic [15:0] pos_col;
  logic [31:0] pos_off;

  // Records produced by the byte being lexed; a byte never gives more than two.
  tok_rec_t run_buf [2];
  int       run_n;

  function automatic bit byte_is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic bit byte_is_letter(input logic [7:0] b);
    return ((b >= CH_LO_A) && (b <= CH_LO_Z)) || ((b >= CH_UP_A) && (b <= CH_UP_Z));
  endfunction

  function automatic bit byte_is_word(input logic [7:0] b);
    return byte_is_letter(b) || byte_is_digit(b) || (b == CH_UNDER);
  endfunction

  function automatic bit byte_is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic bit byte_is_op(input logic [7:0] b);
    case (b)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_AMP, CH_BAR, CH_CARET, CH_TILDE,
      CH_BANG, CH_EQ, CH_LT, CH_GT, CH_QUEST, CH_COLON, CH_HASH, CH_DOT, CH_COMMA:
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

  function automatic void clear_lexer();
    lx_mode      = M_IDLE;
    lx_held      = 8'h00;
    lx_escape    = 1'b0;
    lx_exp_seen  = 1'b0;
    lx_char_step = 2'd0;
    tok_off      = 32'd0;
    tok_len      = 16'd0;
    tok_line     = 16'd1;
    tok_col      = 16'd1;
    pos_line     = 16'd1;
    pos_col      = 16'd1;
    pos_off      = 32'd0;
  endfunction

  function automatic void record_token(input tok_class_e c, input logic [15:0] ln,
                                       input logic [15:0] cl, input logic [31:0] of,
                                       input logic [15:0] le);
    tok_rec_t r;
    r.cls  = c;
    r.line = ln;
    r.col  = cl;
    r.off  = of;
    r.len  = le;
    r.last = 1'b0;
    if (run_n < 2) begin
      run_buf[run_n] = r;
      run_n++;
    end
  endfunction

  // Emits the pending token, if the current mode holds one, and goes idle.
  function automatic void close_pending();
    tok_class_e c;
    case (lx_mode)
      M_IDENT:   c = TC_IDENT;
      M_NUMBER:  c = TC_NUMBER;
      M_CHARLIT: c = TC_CHAR;
      M_STRING:  c = TC_STRING;
      default:   c = TC_OPERATOR;
    endcase
    if (lx_mode != M_IDLE && lx_mode != M_LINECOM && lx_mode != M_BLOCKCOM)
      record_token(c, tok_line, tok_col, tok_off, tok_len);
    lx_mode = M_IDLE;
  endfunction

  function automatic void lengthen();
    if (tok_len != SAT16) tok_len++;
  endfunction

  function automatic void open_pending(input lex_mode_e m);
    lx_mode  = m;
    tok_off  = pos_off;
    tok_len  = 16'd1;
    tok_line = pos_line;
    tok_col  = pos_col;
  endfunction

  // Offers the byte to the current mode; returns 1 if the mode took it.
  function automatic bit absorb_byte(input logic [7:0] b);
    bit took;
    took = 1'b0;
    case (lx_mode)
      M_IDENT: begin
        if (byte_is_word(b)) begin
          lengthen();
          took = 1'b1;
        end
      end
      M_NUMBER: begin
        // Before the exponent digits and dots grow the number; after it digits and e.
        if (!lx_exp_seen) begin
          if (byte_is_digit(b) || b == CH_DOT) begin
            lengthen();
            took = 1'b1;
          end else if (b == CH_LO_E) begin
            lx_exp_seen = 1'b1;
            lengthen();
            took = 1'b1;
          end
        end else if (byte_is_digit(b) || b == CH_LO_E) begin
          lengthen();
          took = 1'b1;
        end
      end
      M_MINUS: begin
        if (byte_is_digit(b) || b == CH_DOT) begin
          lx_mode     = M_NUMBER;
          lx_exp_seen = 1'b0;
          lengthen();
          took = 1'b1;
        end else if (byte_is_op(b)) begin
          lx_mode = M_OPRUN;
          lengthen();
          took = 1'b1;
        end
      end
      M_SLASH: begin
        if (b == CH_SLASH) begin
          lx_mode = M_LINECOM;
          took = 1'b1;
        end else if (b == CH_STAR) begin
          lx_mode = M_BLOCKCOM;
          lx_held = 8'h00;
          took = 1'b1;
        end else if (byte_is_op(b)) begin
          lx_mode = M_OPRUN;
          lengthen();
          took = 1'b1;
        end
      end
      M_OPRUN: begin
        if (byte_is_op(b)) begin
          lengthen();
          took = 1'b1;
        end
      end
      M_CHARLIT: begin
        if (lx_char_step == 2'd0) begin
          lx_char_step = (b == CH_BSLASH) ? 2'd1 : 2'd2;
          lengthen();
          took = 1'b1;
        end else if (lx_char_step == 2'd1) begin
          lx_char_step = 2'd2;
          lengthen();
          took = 1'b1;
        end else if (b == CH_SQUOTE) begin
          lengthen();
          close_pending();
          took = 1'b1;
        end
      end
      M_STRING: begin
        lengthen();
        took = 1'b1;
        if (b == CH_DQUOTE && !lx_escape) close_pending();
        else lx_escape = (b == CH_BSLASH);
      end
      M_LINECOM: begin
        // The newline ends the comment and is then seen as plain whitespace.
        if (b == CH_NL) lx_mode = M_IDLE;
        else took = 1'b1;
      end
      M_BLOCKCOM: begin
        if (lx_held == CH_STAR && b == CH_SLASH) begin
          lx_mode = M_IDLE;
          lx_held = 8'h00;
        end else begin
          lx_held = b;
        end
        took = 1'b1;
      end
      default: ;
    endcase
    return took;
  endfunction

  // A byte that starts a token: either opens a pending token or is a token by itself.
  function automatic void start_byte(input logic [7:0] b);
    tok_class_e c;
    if (byte_is_blank(b)) return;
    if (b == CH_SLASH) begin
      open_pending(M_SLASH);
      return;
    end
    if (b == CH_SQUOTE) begin
      open_pending(M_CHARLIT);
      lx_char_step = 2'd0;
      return;
    end
    if (b == CH_DQUOTE) begin
      open_pending(M_STRING);
      lx_escape = 1'b0;
      return;
    end
    if (byte_is_letter(b) || b == CH_UNDER) begin
      open_pending(M_IDENT);
      return;
    end
    if (b == CH_MINUS) begin
      open_pending(M_MINUS);
      return;
    end
    if (byte_is_digit(b)) begin
      open_pending(M_NUMBER);
      lx_exp_seen = 1'b0;
      return;
    end
    if (byte_is_op(b)) begin
      open_pending(M_OPRUN);
      return;
    end
    case (b)
      CH_LPAREN: c = TC_LPAREN;
      CH_RPAREN: c = TC_RPAREN;
      CH_LBRACE: c = TC_LBRACE;
      CH_RBRACE: c = TC_RBRACE;
      CH_LBRACK: c = TC_LBRACK;
      CH_RBRACK: c = TC_RBRACK;
      CH_SEMI:   c = TC_SEMICOLON;
      default:   c = TC_UNKNOWN;
    endcase
    record_token(c, pos_line, pos_col, pos_off, 16'd1);
  endfunction

  // Lexes one accepted byte and queues the token records it should produce.
  function automatic void lex_byte(input logic [7:0] b, input logic eot);
    tok_rec_t r;
    run_n = 0;
    if (lx_mode == M_IDLE || !absorb_byte(b)) begin
      close_pending();
      start_byte(b);
    end
    if (eot) begin
      // End of text flushes the pending token and restarts at line 1, column 1, offset 0.
      close_pending();
      clear_lexer();
    end else begin
      if (b == CH_NL) begin
        if (pos_line != SAT16) pos_line++;
        pos_col = 16'd1;
      end else if (pos_col != SAT16) begin
        pos_col++;
      end
      pos_off++;
    end
    for (int i = 0; i < run_n; i++) begin
      r      = run_buf[i];
      r.last = (i == run_n - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Receiver: checks every accepted record beat against the oldest expectation and
  // drives the stall, either at random or as one long counted hold-off.
  always @(posedge clk_i) begin
    tok_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        $error("token record with none expected: class %0d offset %0d",
               token_class_o, token_offset_o);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_class", 32'(want.cls), 32'(token_class_o));
        check_field("token_line", 32'(want.line), 32'(token_line_o));
        check_field("token_column", 32'(want.col), 32'(token_column_o));
        check_field("token_offset", want.off, token_offset_o);
        check_field("token_length", 32'(want.len), 32'(token_length_o));
        check_field("last_of_run", 32'(want.last), 32'(last_of_run_o));
        tokens_checked++;
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(0, 99) < 17);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("c_like_lexer_unit_tb: errors");
      $finish;
    end
  end

  // Offers one byte beat and waits for it to be taken. Valid stays high afterwards so
  // that back-to-back beats need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (idle_on && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lex_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_string(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  // Random text bytes end the text now and then.
  task automatic send_text_byte(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 99) < 2);
  endtask

  // Stops offering and waits until every owed record has come out.
  task automatic wait_for_tokens();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(CH_LO_A + r);
    if (r < 52) return 8'(CH_UP_A + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 17))
      0:  return CH_PLUS;
      1:  return CH_MINUS;
      2:  return CH_STAR;
      3:  return CH_SLASH;
      4:  return CH_PCT;
      5:  return CH_AMP;
      6:  return CH_BAR;
      7:  return CH_CARET;
      8:  return CH_TILDE;
      9:  return CH_BANG;
      10: return CH_EQ;
      11: return CH_LT;
      12: return CH_GT;
      13: return CH_QUEST;
      14: return CH_COLON;
      15: return CH_HASH;
      16: return CH_DOT;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(0, 6))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_LBRACE;
      3: return CH_RBRACE;
      4: return CH_LBRACK;
      5: return CH_RBRACK;
      default: return CH_SEMI;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return CH_VTAB;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Sends one random piece of text: mostly well-formed tokens and comments with random
  // content, some broken fragments and raw noise.
  task automatic send_piece();
    int unsigned n;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        send_text_byte(pick_letter());
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          send_text_byte(($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter());
      end
      3, 4: begin
        if ($urandom_range(0, 2) == 0) begin
          send_text_byte(CH_MINUS);
          send_text_byte(($urandom_range(0, 3) == 0) ? CH_DOT : pick_digit());
        end else begin
          send_text_byte(pick_digit());
        end
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
          send_text_byte(($urandom_range(0, 3) == 0) ? CH_DOT : pick_digit());
        if ($urandom_range(0, 2) == 0) begin
          send_text_byte(CH_LO_E);
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++)
            send_text_byte(($urandom_range(0, 4) == 0) ? CH_LO_E : pick_digit());
        end
      end
      5, 6: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_text_byte(pick_op());
      end
      7: begin
        send_text_byte(CH_SQUOTE);
        if ($urandom_range(0, 2) == 0) send_text_byte(CH_BSLASH);
        send_text_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0) send_text_byte(CH_SQUOTE);
      end
      8: begin
        send_text_byte(CH_DQUOTE);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 9))
            0, 1:    send_text_byte(CH_BSLASH);
            2:       send_text_byte(CH_DQUOTE);
            3, 4, 5: send_text_byte(pick_letter());
            default: send_text_byte(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 9) != 0) send_text_byte(CH_DQUOTE);
      end
      9: begin
        send_text_byte(CH_SLASH);
        send_text_byte(CH_SLASH);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) send_text_byte(pick_letter());
        send_text_byte(CH_NL);
      end
      10: begin
        send_text_byte(CH_SLASH);
        send_text_byte(CH_STAR);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          send_text_byte(($urandom_range(0, 2) == 0) ? CH_STAR : 8'($urandom_range(0, 255)));
        send_text_byte(CH_STAR);
        send_text_byte(CH_SLASH);
      end
      11, 12: send_text_byte(pick_delim());
      13, 14, 15: send_text_byte(pick_blank());
      16: send_text_byte(8'($urandom_range(0, 255)));
      default: begin
        // Fragments that open a token or comment and may leave it dangling.
        case ($urandom_range(0, 7))
          0: send_text_byte(CH_SLASH);
          1: send_text_byte(CH_MINUS);
          2: send_text_byte(CH_SQUOTE);
          3: send_text_byte(CH_DQUOTE);
          4: send_text_byte(CH_STAR);
          5: send_text_byte(CH_BSLASH);
          6: send_text_byte(CH_LO_E);
          default: send_text_byte(CH_DOT);
        endcase
      end
    endcase
  endtask

  // Identifier, number, operator, char, string, left paren and semicolon tokens, a byte that
  // gives two records, lone minus and slash, comment marks inside an operator run, a block
  // comment, an escaped char and string, the byte extremes and an end of text.
  task automatic test_directed_tokens();
    send_string("a(-.5e9-x/y+//c\n/**/'\\'\"\\\"\";", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_for_tokens();
  endtask

  // The receiver holds off for a long stretch while bytes keep coming, so the record
  // queue fills and the input stalls; then the sender pauses until all has drained.
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    for (int i = 0; i < 10; i++) send_string("x(;)", 1'b0);
    wait_for_tokens();
  endtask

  // Random text, with one stretch in the middle where neither side idles.
  task automatic test_random_text();
    int unsigned first;
    first = bytes_sent;
    while (bytes_sent < first + RANDOM_BYTES) begin
      idle_on = !((bytes_sent >= first + 700) && (bytes_sent < first + 1100));
      send_piece();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    clear_lexer();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_tokens();
    test_backpressure();
    test_random_text();
    wait_for_tokens();
    repeat (6) @(posedge clk_i);
    if (expected_tokens.size() != 0) begin
      $error("%0d token records never arrived", expected_tokens.size());
      fail_count++;
    end
    $display("Run covered %0d text bytes and %0d token records of every class,",
             bytes_sent, tokens_checked);
    $display("with comments, end-of-text flushes, a long receiver hold-off and input stall.");
    if (fail_count == 0) begin
      $display("c_like_lexer_unit_tb: clean");
    end else begin
      $display("c_like_lexer_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cll_pkg.sv
src/cll_fifo.sv
src/c_like_lexer_unit.sv
verif/c_like_lexer_unit_tb.sv
